@@ sv/rpc_pkg.sv @@
// ----------------------------------------------------------------------------
// rpc_pkg: shared types and constants for the reflow profile controller
// Holds the configuration bundle, the per-tick result bundle, register
// indexes and the reset values of the profile registers.
// ----------------------------------------------------------------------------
package rpc_pkg;

  localparam int unsigned FrameW   = 32;
  localparam int unsigned TempW    = 14;
  localparam int unsigned TempLsb  = 18;
  localparam int unsigned SecW     = 16;
  localparam int unsigned TargetW  = 11;
  localparam int unsigned DriveW   = 7;
  localparam int unsigned PhaseW   = 3;
  localparam int unsigned CountW   = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned OutDataW = 64;

  localparam logic [CountW-1:0] StopHoldSeconds = 32'd5;
  localparam logic [DriveW-1:0] DriveMax        = 7'd99;

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] RegPresoakSeconds = 3'd0;
  localparam logic [CfgIdxW-1:0] RegPresoakTarget  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegSoakSeconds    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSoakTarget     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegReflowSeconds  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegReflowTarget   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegCoolingSeconds = 3'd6;
  localparam logic [CfgIdxW-1:0] RegCoolingTarget  = 3'd7;

  // reset values
  localparam logic [SecW-1:0]    RstPresoakSeconds = 16'd40;
  localparam logic [TargetW-1:0] RstPresoakTarget  = 11'd30;
  localparam logic [SecW-1:0]    RstSoakSeconds    = 16'd180;
  localparam logic [TargetW-1:0] RstSoakTarget     = 11'd30;
  localparam logic [SecW-1:0]    RstReflowSeconds  = 16'd50;
  localparam logic [TargetW-1:0] RstReflowTarget   = 11'd100;
  localparam logic [SecW-1:0]    RstCoolingSeconds = 16'd100;
  localparam logic [TargetW-1:0] RstCoolingTarget  = 11'd20;

  typedef struct packed {
    logic [SecW-1:0]    presoak_seconds;
    logic [TargetW-1:0] presoak_target;
    logic [SecW-1:0]    soak_seconds;
    logic [TargetW-1:0] soak_target;
    logic [SecW-1:0]    reflow_seconds;
    logic [TargetW-1:0] reflow_target;
    logic [SecW-1:0]    cooling_seconds;
    logic [TargetW-1:0] cooling_target;
  } rpc_cfg_t;

  typedef struct packed {
    logic [CountW-1:0]       elapsed_seconds;
    logic signed [TempW-1:0] hot_temp_quarters;
    logic                    phase_changed;
    logic [PhaseW-1:0]       phase_now;
    logic [DriveW-1:0]       drive_level;
  } rpc_res_t;

endpackage

@@ sv/reflow_profile_controller.sv @@
// ----------------------------------------------------------------------------
// reflow_profile_controller: reflow oven profile sequencer, P-controller
// Takes one thermocouple frame per one-second tick and returns heater drive,
// profile phase and change flag, hot temperature and saturating seconds count.
// ----------------------------------------------------------------------------
// Throughput is one tick per clock unless the result stream stalls; a tick
// passes the input register, then the result register. The combinational
// sequencer step, which must finish before the next tick uses the updated
// phase, sets that rate. A result waiting on a stalled output does not block
// the next input transfer: the input register holds it until the result
// register drains. Each tick increments the seconds counter (saturating at
// all ones), reads the signed quarter-degree hot junction from frame bits
// 31..18 and steps the profile stop, pre-soak, soak, reflow, cooling, stop.
// Stop drives zero and leaves once the counter passes five; each timed phase
// ends when the counter passes its entry time plus its duration. Drive is
// 10*(target-temp) truncated and clamped to 0..99, taken from the phase
// current at the start of the tick. The user must write profile registers
// via cfg_we_i/cfg_idx_i/cfg_data_i while idle; the block does not check.
// ----------------------------------------------------------------------------
module reflow_profile_controller import rpc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration writes
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // tick input stream
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [FrameW-1:0]   s_axis_tdata_i,  // [31:0] tc_frame
  // result stream
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [6:0] drive_level, [9:7] phase_now, [10] phase_changed,
  // [24:11] hot_temp_quarters, [56:25] elapsed_seconds, [63:57] zero
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  localparam int unsigned ResW = $bits(rpc_res_t);

  rpc_cfg_t cfg;
  rpc_res_t res;

  logic              in_valid_q, in_valid_d;
  logic [FrameW-1:0] in_frame_q;
  logic              out_valid_q, out_valid_d;
  rpc_res_t          out_res_q;
  logic              advance;

  rpc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Advance a tick whenever the result register is free or draining.
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  assign in_valid_d  = s_axis_tready_o ? s_axis_tvalid_i : in_valid_q;
  assign out_valid_d = advance ? 1'b1 : (m_axis_tready_i ? 1'b0 : out_valid_q);

  rpc_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .frame_i   (in_frame_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers: load on transfer, hold otherwise
  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_frame_q <= s_axis_tdata_i;
    end
    if (advance) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutDataW - ResW){1'b0}}, out_res_q};

  // a result appears only after a tick sat in the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_valid_q))
    else $error("result valid without a pending tick");

  // a pending tick with an empty result register must move on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_valid_q) |=> out_valid_q)
    else $error("pending tick not advanced");

  // drive never exceeds the clamp
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_res_q.drive_level <= DriveMax))
    else $error("drive level above clamp");

endmodule

@@ sv/rpc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// rpc_cfg_regs: profile register file
// Eight write-only registers holding phase durations and targets.
// ----------------------------------------------------------------------------
module rpc_cfg_regs import rpc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output rpc_cfg_t            cfg_o
);

  rpc_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegPresoakSeconds: cfg_d.presoak_seconds = cfg_data_i;
        RegPresoakTarget:  cfg_d.presoak_target  = cfg_data_i[TargetW-1:0];
        RegSoakSeconds:    cfg_d.soak_seconds    = cfg_data_i;
        RegSoakTarget:     cfg_d.soak_target     = cfg_data_i[TargetW-1:0];
        RegReflowSeconds:  cfg_d.reflow_seconds  = cfg_data_i;
        RegReflowTarget:   cfg_d.reflow_target   = cfg_data_i[TargetW-1:0];
        RegCoolingSeconds: cfg_d.cooling_seconds = cfg_data_i;
        RegCoolingTarget:  cfg_d.cooling_target  = cfg_data_i[TargetW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.presoak_seconds <= RstPresoakSeconds;
      cfg_q.presoak_target  <= RstPresoakTarget;
      cfg_q.soak_seconds    <= RstSoakSeconds;
      cfg_q.soak_target     <= RstSoakTarget;
      cfg_q.reflow_seconds  <= RstReflowSeconds;
      cfg_q.reflow_target   <= RstReflowTarget;
      cfg_q.cooling_seconds <= RstCoolingSeconds;
      cfg_q.cooling_target  <= RstCoolingTarget;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ sv/rpc_step.sv @@
// ----------------------------------------------------------------------------
// rpc_step: profile sequencer and proportional drive
// Holds phase, seconds counter and phase entry time; computes the result of
// one tick and commits the new state when the tick advances.
// ----------------------------------------------------------------------------
module rpc_step import rpc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  logic [FrameW-1:0] frame_i,
  input  rpc_cfg_t          cfg_i,
  output rpc_res_t          res_o
);

  typedef enum logic [PhaseW-1:0] {
    PhStop    = 3'd0,
    PhPresoak = 3'd1,
    PhSoak    = 3'd2,
    PhReflow  = 3'd3,
    PhCooling = 3'd4
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [CountW-1:0] count_q, count_d;
  logic [CountW-1:0] start_q;

  logic signed [TempW-1:0] hot;
  logic [TargetW-1:0]      target;
  logic [SecW-1:0]         duration;
  logic                    timed;
  logic signed [15:0]      err;
  logic [5:0]              err_lo;
  logic [8:0]              prod;
  logic [DriveW-1:0]       drive;
  logic                    done;
  logic                    changed;

  assign hot     = frame_i[TempLsb +: TempW];
  assign count_d = (count_q != '1) ? count_q + 1'b1 : count_q;

  always_comb begin
    target   = '0;
    duration = '0;
    timed    = 1'b1;
    unique case (phase_q)
      PhPresoak: begin
        target   = cfg_i.presoak_target;
        duration = cfg_i.presoak_seconds;
      end
      PhSoak: begin
        target   = cfg_i.soak_target;
        duration = cfg_i.soak_seconds;
      end
      PhReflow: begin
        target   = cfg_i.reflow_target;
        duration = cfg_i.reflow_seconds;
      end
      PhCooling: begin
        target   = cfg_i.cooling_target;
        duration = cfg_i.cooling_seconds;
      end
      default: timed = 1'b0;
    endcase
  end

  // error in quarter degrees; drive = floor(10*err/4), clamped to 99 from err 40
  assign err    = $signed({3'b000, target, 2'b00}) - $signed({{2{hot[TempW-1]}}, hot});
  assign err_lo = err[5:0];
  assign prod   = {err_lo, 3'b000} + {2'b00, err_lo, 1'b0};

  always_comb begin
    priority if (!timed || err <= 16'sd0) begin
      drive = '0;
    end else if (err >= 16'sd40) begin
      drive = DriveMax;
    end else begin
      drive = prod[8:2];
    end
  end

  assign done = {1'b0, count_d} > ({1'b0, start_q} + {17'd0, duration});

  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PhPresoak: if (done) phase_d = PhSoak;
      PhSoak:    if (done) phase_d = PhReflow;
      PhReflow:  if (done) phase_d = PhCooling;
      PhCooling: if (done) phase_d = PhStop;
      default:   phase_d = (count_d > StopHoldSeconds) ? PhPresoak : PhStop;
    endcase
  end

  assign changed = (phase_d != phase_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhStop;
      count_q <= '0;
      start_q <= '0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      if (changed) begin
        start_q <= count_d;
      end
    end
  end

  always_comb begin
    res_o.drive_level       = drive;
    res_o.phase_now         = phase_d;
    res_o.phase_changed     = changed;
    res_o.hot_temp_quarters = hot;
    res_o.elapsed_seconds   = count_d;
  end

endmodule

@@ test/reflow_profile_controller_tb.sv @@
// ----------------------------------------------------------------------------
// reflow_profile_controller_tb: self-checking bench for the reflow sequencer
// Feeds one thermocouple frame per transfer and checks every result transfer,
// field by field, against the directed table or an in-bench sequencer model.
// A short directed table comes first, then random ticks under a series of
// profile settings; both stream sides see random gaps, save in the last two.
// ----------------------------------------------------------------------------
module reflow_profile_controller_tb;
  import rpc_pkg::*;

  typedef enum logic [PhaseW-1:0] {
    PhStop    = 3'd0,
    PhPresoak = 3'd1,
    PhSoak    = 3'd2,
    PhReflow  = 3'd3,
    PhCooling = 3'd4
  } profile_phase_e;

  localparam int DriveGain      = 10;
  localparam int QuartersPerDeg = 4;
  localparam int ResLsbW        = $bits(rpc_res_t);
  // Longest legal quiet stretch comes from random gaps, eight register writes
  // and the drain pause; allow far more than that.
  localparam int StallLimit     = 2000;
  localparam int TicksPerPhase  = 85;

  // one row of the directed table; expected fields are only used when typed
  typedef struct {
    logic [FrameW-1:0] frame;
    bit                typed;
    logic [DriveW-1:0] drive;
    profile_phase_e    phase;
    bit                changed;
    logic [CountW-1:0] secs;
  } tick_row_t;

  typedef struct {
    logic [FrameW-1:0] frame;
    bit                typed;
    rpc_res_t          want;
  } tick_offer_t;

  logic                clk_i;
  logic                rst_ni          = 1'b0;
  logic                cfg_we_i        = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i       = '0;
  logic [CfgDataW-1:0] cfg_data_i      = '0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [FrameW-1:0]   s_axis_tdata_i  = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;

  reflow_profile_controller dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),   // [31:0] tc_frame
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    // [6:0] drive_level, [9:7] phase_now, [10] phase_changed,
    // [24:11] hot_temp_quarters, [56:25] elapsed_seconds, [63:57] zero
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Sequencer model: profile registers, phase, seconds count, phase entry time
  // --------------------------------------------------------------------------
  rpc_cfg_t          profile_cfg;
  profile_phase_e    phase_q;
  logic [CountW-1:0] seconds_q;
  logic [CountW-1:0] phase_entry_q;

  tick_offer_t ticks_offered[$];     // frames handed to the driver, in order
  rpc_res_t    tick_results_due[$];  // results owed by the block, oldest first

  int mismatches    = 0;
  int quiet_cycles  = 0;
  int send_idle_pct = 33;
  int recv_idle_pct = 54;

  function automatic logic [TargetW-1:0] phase_target(profile_phase_e ph);
    case (ph)
      PhSoak:    return profile_cfg.soak_target;
      PhReflow:  return profile_cfg.reflow_target;
      PhCooling: return profile_cfg.cooling_target;
      default:   return profile_cfg.presoak_target;
    endcase
  endfunction

  // Advance the model by one tick and return the result it owes.
  function automatic rpc_res_t profile_step(logic [FrameW-1:0] frame);
    logic signed [TempW-1:0] temp_q;
    logic [SecW-1:0]         span;
    profile_phase_e          follow;
    profile_phase_e          nxt;
    int                      err;
    int                      lvl;
    rpc_res_t                r;
    temp_q = frame[TempLsb +: TempW];
    // saturate the seconds count
    if (seconds_q != '1) seconds_q = seconds_q + 1'b1;
    lvl = 0;
    nxt = phase_q;
    case (phase_q)
      PhPresoak: begin span = profile_cfg.presoak_seconds; follow = PhSoak;    end
      PhSoak:    begin span = profile_cfg.soak_seconds;    follow = PhReflow;  end
      PhReflow:  begin span = profile_cfg.reflow_seconds;  follow = PhCooling; end
      default:   begin span = profile_cfg.cooling_seconds; follow = PhStop;    end
    endcase
    if (phase_q == PhStop) begin
      // stop holds until the absolute count passes the hold time
      nxt = (seconds_q > StopHoldSeconds) ? PhPresoak : PhStop;
    end else begin
      // drive follows the phase current at the start of the tick
      err = QuartersPerDeg * int'(phase_target(phase_q)) - int'(temp_q);
      if (err > 0) lvl = (err * DriveGain) / QuartersPerDeg;
      if (lvl > int'(DriveMax)) lvl = int'(DriveMax);
      // phase end compared without wrap
      if ({1'b0, seconds_q} > {1'b0, phase_entry_q} + {17'd0, span}) nxt = follow;
    end
    r.phase_changed = (nxt != phase_q);
    if (r.phase_changed) phase_entry_q = seconds_q;
    phase_q             = nxt;
    r.drive_level       = lvl[DriveW-1:0];
    r.phase_now         = phase_q;
    r.hot_temp_quarters = temp_q;
    r.elapsed_seconds   = seconds_q;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Directed ticks, under the reset profile (pre-soak target 30 degrees, i.e.
  // 120 quarters). Stop runs for five seconds; the sixth tick enters pre-soak
  // with zero drive, since the drive follows the old phase. Then extremes of
  // the temperature field and the edges of the proportional band.
  // --------------------------------------------------------------------------
  tick_row_t directed_ticks [22] = '{
    '{32'h0000_0000, 1'b1, 7'd0,  PhStop,    1'b0, 32'd1},
    '{32'hFFFF_FFFF, 1'b1, 7'd0,  PhStop,    1'b0, 32'd2},
    '{32'h7FFF_FFFF, 1'b1, 7'd0,  PhStop,    1'b0, 32'd3},
    '{32'h8000_0000, 1'b1, 7'd0,  PhStop,    1'b0, 32'd4},   // cold, still stop
    '{32'h01DC_0000, 1'b1, 7'd0,  PhStop,    1'b0, 32'd5},
    '{32'h8000_0000, 1'b1, 7'd0,  PhPresoak, 1'b1, 32'd6},   // enter pre-soak
    '{32'h8000_0000, 1'b1, 7'd99, PhPresoak, 1'b0, 32'd7},   // coldest: clamp
    '{32'h7FFF_FFFF, 1'b1, 7'd0,  PhPresoak, 1'b0, 32'd8},   // hottest
    '{32'h01E0_0000, 1'b1, 7'd0,  PhPresoak, 1'b0, 32'd9},   // on target
    '{32'h01DC_0000, 1'b1, 7'd2,  PhPresoak, 1'b0, 32'd10},  // one quarter low
    '{32'h01D8_0000, 1'b1, 7'd5,  PhPresoak, 1'b0, 32'd11},
    '{32'h01D4_0000, 1'b1, 7'd7,  PhPresoak, 1'b0, 32'd12},  // truncation
    '{32'h0144_0000, 1'b1, 7'd97, PhPresoak, 1'b0, 32'd13},  // just below clamp
    '{32'h0140_0000, 1'b1, 7'd99, PhPresoak, 1'b0, 32'd14},  // clamp reached
    '{32'h01E4_0000, 1'b1, 7'd0,  PhPresoak, 1'b0, 32'd15},  // one quarter high
    '{32'hA5A5_5A5A, 1'b0, 7'd0,  PhStop,    1'b0, 32'd0},
    '{32'h0FF0_0FF0, 1'b0, 7'd0,  PhStop,    1'b0, 32'd0},
    '{32'h1234_5678, 1'b0, 7'd0,  PhStop,    1'b0, 32'd0},
    '{32'hDEAD_BEEF, 1'b0, 7'd0,  PhStop,    1'b0, 32'd0},
    '{32'h0000_3FFF, 1'b0, 7'd0,  PhStop,    1'b0, 32'd0},
    '{32'h0204_0000, 1'b0, 7'd0,  PhStop,    1'b0, 32'd0},
    '{32'h0100_0000, 1'b0, 7'd0,  PhStop,    1'b0, 32'd0}
  };

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Receiver: drop tready at random per the current idle share.
  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Hold tvalid across back-to-back frames; lower it only for a gap.
  task automatic offer_tick(input logic [FrameW-1:0] frame, input bit typed,
                            input rpc_res_t want);
    ticks_offered.push_back('{frame, typed, want});
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= $urandom;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= frame;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // Write all eight profile registers on consecutive cycles, model alongside.
  task automatic load_profile(input logic [CfgDataW-1:0] vals [8]);
    logic [CfgIdxW-1:0] idx;
    for (int i = 0; i < 8; i++) begin
      idx = CfgIdxW'(i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx;
      cfg_data_i <= vals[i];
      case (idx)
        RegPresoakSeconds: profile_cfg.presoak_seconds = vals[i];
        RegPresoakTarget:  profile_cfg.presoak_target  = vals[i][TargetW-1:0];
        RegSoakSeconds:    profile_cfg.soak_seconds    = vals[i];
        RegSoakTarget:     profile_cfg.soak_target     = vals[i][TargetW-1:0];
        RegReflowSeconds:  profile_cfg.reflow_seconds  = vals[i];
        RegReflowTarget:   profile_cfg.reflow_target   = vals[i][TargetW-1:0];
        RegCoolingSeconds: profile_cfg.cooling_seconds = vals[i];
        default:           profile_cfg.cooling_target  = vals[i][TargetW-1:0];
      endcase
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Drop tvalid, wait for every owed result, then let the pipeline empty.
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (tick_results_due.size() != 0 || ticks_offered.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Mostly temperatures near the current target so the drive sweeps its band;
  // some fully random frames and some at the temperature extremes.
  function automatic logic [FrameW-1:0] random_frame();
    logic [TempW-1:0] q;
    int               centre;
    centre = QuartersPerDeg * int'(phase_target(phase_q));
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       q = $urandom_range(0, 1) ? 14'h2000 : 14'h1FFF;
      default: q = TempW'(centre - 50 + int'($urandom_range(0, 60)));
    endcase
    return {q, 18'($urandom)};
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: check result transfers first, then log input transfers, so a
  // result can never be matched against a tick accepted in the same cycle.
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    rpc_res_t    got;
    rpc_res_t    want;
    tick_offer_t t;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      got = rpc_res_t'(m_axis_tdata_o[ResLsbW-1:0]);
      if (tick_results_due.size() == 0) begin
        $display("%0t: result transfer with no tick owed: %h", $time, m_axis_tdata_o);
        mismatches++;
      end else begin
        want = tick_results_due.pop_front();
        check_field("drive_level", 32'(want.drive_level), 32'(got.drive_level));
        check_field("phase_now", 32'(want.phase_now), 32'(got.phase_now));
        check_field("phase_changed", 32'(want.phase_changed), 32'(got.phase_changed));
        check_field("hot_temp_quarters", 32'(unsigned'(want.hot_temp_quarters)),
                    32'(unsigned'(got.hot_temp_quarters)));
        check_field("elapsed_seconds", want.elapsed_seconds, got.elapsed_seconds);
        check_field("pad bits", 32'd0, 32'(m_axis_tdata_o[OutDataW-1:ResLsbW]));
      end
    end
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      t    = ticks_offered.pop_front();
      want = profile_step(s_axis_tdata_i);
      tick_results_due.push_back(t.typed ? t.want : want);
    end
    // watchdog on cycles with no transfer on either side
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("reflow_profile_controller_tb failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [CfgDataW-1:0] vals [8];
    rpc_res_t            want;
    tick_row_t           row;

    profile_cfg = '{presoak_seconds: RstPresoakSeconds, presoak_target: RstPresoakTarget,
                    soak_seconds: RstSoakSeconds,       soak_target: RstSoakTarget,
                    reflow_seconds: RstReflowSeconds,   reflow_target: RstReflowTarget,
                    cooling_seconds: RstCoolingSeconds, cooling_target: RstCoolingTarget};
    phase_q       = PhStop;
    seconds_q     = '0;
    phase_entry_q = '0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table under the reset profile
    foreach (directed_ticks[i]) begin
      row  = directed_ticks[i];
      want = '{elapsed_seconds: row.secs, hot_temp_quarters: row.frame[TempLsb +: TempW],
               phase_changed: row.changed, phase_now: row.phase, drive_level: row.drive};
      offer_tick(row.frame, row.typed, want);
    end
    drain_results();

    // Random ticks under six profiles. Counter saturation needs 2^32 ticks
    // and is out of reach in one run without a second reset.
    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        send_idle_pct = 54;
        recv_idle_pct = 33;
      end else if (p == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (p)
        // zero and short durations; targets masked from all-ones / bit 11
        0: vals = '{16'd0, 16'hFFFF, 16'd1, 16'd0, 16'd2, 16'd2047, 16'd3, 16'd30};
        1: vals = '{16'd4, 16'd100, 16'd0, 16'd200, 16'd3, 16'h0800, 16'd1, 16'd25};
        // cooling never ends within the phase
        4: vals = '{16'd2, 16'd60, 16'd3, 16'd70, 16'd1, 16'd90, 16'hFFFF, 16'd40};
        // release cooling at once, then hold pre-soak at the longest duration
        5: vals = '{16'hFFFF, 16'd0, 16'hFFFF, 16'd2047, 16'hFFFF, 16'd0, 16'd0, 16'd2047};
        default: begin
          for (int i = 0; i < 8; i++) begin
            vals[i] = (i % 2 == 0) ? CfgDataW'($urandom_range(0, 6))
                                   : CfgDataW'($urandom_range(0, 65535));
          end
        end
      endcase
      load_profile(vals);
      repeat (TicksPerPhase) offer_tick(random_frame(), 1'b0, '0);
      drain_results();
    end

    if (mismatches == 0) begin
      $display("reflow_profile_controller_tb passed");
    end else begin
      $display("reflow_profile_controller_tb failed");
    end
    $finish;
  end

endmodule
